// ===== rtl/sha256_stream_hasher_assert.svh =====
// assertion macros for the sha-256 stream hasher checker
// expects clk and rst_n in the scope of each use
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// same-cycle implication
`define SHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 stream hasher: same-cycle check failed");

// next-cycle implication
`define SHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 stream hasher: next-cycle check failed");

// condition that must never hold
`define SHS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sha256 stream hasher: forbidden condition seen");

`endif

// ===== rtl/shs_pkg.sv =====
// shared types, constants and round functions of the sha-256 stream hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef logic [0:7][31:0] hash_t;

  typedef struct packed {
    logic       load_byte;
    logic [7:0] blk_byte;
    logic       start;
    logic       restart;
  } core_ctrl_t;

  typedef struct packed {
    logic  done;
    hash_t hash_words;
  } core_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_OUT
  } state_t;

  localparam logic [5:0]  FILL_LAST     = 6'd63;
  localparam logic [5:0]  LEN_POS       = 6'd56;
  localparam logic [5:0]  ROUND_LAST    = 6'd63;
  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam logic [63:0] BYTE_BITS     = 64'd8;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd7;

  localparam hash_t HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/shs_core.sv =====
// sha-256 compression core: 512-bit block buffer that doubles as the schedule
// window, one round per cycle, then the chaining add; uses shs_pkg
`timescale 1ns / 1ps
`default_nettype none

module shs_core
  import shs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  core_ctrl_t ctrl,
  output core_stat_t stat
);

  logic [511:0] blk_r;
  hash_t        h_r;
  hash_t        v_r;
  hash_t        v_nxt;
  logic [5:0]   rnd_r;
  logic         run_r;
  logic         upd_r;

  logic [31:0] w_t;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch_v;
  logic [31:0] maj_v;

  // window word i sits at blk_r[511-32*i -: 32]
  assign w_t   = blk_r[511:480];
  assign w_new = w_t + sml_sig0(blk_r[479:448]) + blk_r[223:192] + sml_sig1(blk_r[63:32]);

  always_comb begin
    ch_v  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj_v = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + big_sig1(v_r[4]) + ch_v + ROUND_K[rnd_r] + w_t;
    t2    = big_sig0(v_r[0]) + maj_v;
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_r[0];
    v_nxt[2] = v_r[1];
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[5] = v_r[4];
    v_nxt[6] = v_r[5];
    v_nxt[7] = v_r[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      upd_r <= 1'b0;
      rnd_r <= '0;
      h_r   <= HASH_IV;
    end else begin
      upd_r <= run_r && (rnd_r == ROUND_LAST);
      if (ctrl.start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          run_r <= 1'b0;
        end
      end
      if (upd_r) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end else if (ctrl.restart) begin
        h_r <= HASH_IV;
      end
    end
  end

  // block buffer and working variables
  always_ff @(posedge clk) begin
    if (ctrl.load_byte) begin
      blk_r <= {blk_r[503:0], ctrl.blk_byte};
    end else if (run_r) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (ctrl.start) begin
      v_r <= h_r;
    end else if (run_r) begin
      v_r <= v_nxt;
    end
  end

  assign stat.done       = upd_r;
  assign stat.hash_words = h_r;

endmodule

`default_nettype wire

// ===== rtl/sha256_stream_hasher.sv =====
// sha-256 stream hasher top level: byte intake, padding sequencer, digest output
// uses shs_pkg and shs_core
//
// usage
//   in_valid/in_ready/in_data: one transfer per item; an item may carry one
//   message byte (has_byte) and may mark the end of the message (last)
//   out_valid/out_ready/out_data: eight transfers per message, digest words
//   0..7, last_word set on word 7; nothing for other items
//   the 64th byte of a block starts the compression (64 rounds of the shared
//   round unit plus the chaining add); a last item runs the padding one byte
//   per cycle, pausing before the length field and during compression, with
//   one or two compressions in all
//   in_ready is low during compression, padding and digest output
//   if the receiver stalls, the current digest word holds and nothing is taken
//   reset (rst_n low, synchronous) loads the initial hash values and clears
//   the byte count, bit length and sequencer
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher
  import shs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t      state_r;
  state_t      state_nxt;
  state_t      ret_r;
  state_t      ret_nxt;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [2:0]  idx_r;

  core_ctrl_t  ctrl;
  core_stat_t  stat;
  logic        bit_add;
  logic        len_shift;

  shs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.has_byte && (fill_r == FILL_LAST)) begin
            state_nxt = ST_HASH;
            ret_nxt   = in_data.last ? ST_PAD_MARK : ST_IDLE;
          end else if (in_data.last) begin
            state_nxt = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_HASH;
          ret_nxt   = ST_PAD_ZERO;
        end else begin
          state_nxt = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (fill_r == LEN_POS) begin
          state_nxt = ST_PAD_LEN;
        end else if (fill_r == FILL_LAST) begin
          state_nxt = ST_HASH;
          ret_nxt   = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_HASH;
          ret_nxt   = ST_OUT;
        end
      end
      ST_HASH: begin
        if (stat.done) begin
          state_nxt = ret_r;
        end
      end
      ST_OUT: begin
        if (out_ready && (idx_r == LAST_WORD_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    ctrl.load_byte = 1'b0;
    ctrl.blk_byte  = '0;
    ctrl.start     = 1'b0;
    ctrl.restart   = 1'b0;
    bit_add        = 1'b0;
    len_shift      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.has_byte) begin
          ctrl.load_byte = 1'b1;
          ctrl.blk_byte  = in_data.data_byte;
          ctrl.start     = (fill_r == FILL_LAST);
          bit_add        = 1'b1;
        end
      end
      ST_PAD_MARK: begin
        ctrl.load_byte = 1'b1;
        ctrl.blk_byte  = PAD_BYTE;
        ctrl.start     = (fill_r == FILL_LAST);
      end
      ST_PAD_ZERO: begin
        if (fill_r != LEN_POS) begin
          ctrl.load_byte = 1'b1;
          ctrl.start     = (fill_r == FILL_LAST);
        end
      end
      ST_PAD_LEN: begin
        ctrl.load_byte = 1'b1;
        ctrl.blk_byte  = bits_r[63:56];
        ctrl.start     = (fill_r == FILL_LAST);
        len_shift      = 1'b1;
      end
      ST_HASH: begin
      end
      ST_OUT: begin
        out_valid    = 1'b1;
        ctrl.restart = out_ready && (idx_r == LAST_WORD_IDX);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (ctrl.load_byte) begin
        fill_r <= fill_r + 6'd1;
      end
      // length bytes shift out msb first, leaving zero for the next message
      if (bit_add) begin
        bits_r <= bits_r + BYTE_BITS;
      end else if (len_shift) begin
        bits_r <= {bits_r[55:0], 8'h00};
      end
      if (out_valid && out_ready) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  assign out_data.digest_word = stat.hash_words[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == LAST_WORD_IDX);

endmodule

`default_nettype wire

// ===== rtl/shs_checker.sv =====
// port-level checks of the sha-256 stream hasher, bound to the top level
// uses shs_pkg and sha256_stream_hasher_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "sha256_stream_hasher_assert.svh"

module shs_checker
  import shs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // no intake while a digest is being delivered
  `SHS_ASSERT_NEVER(a_no_overlap, in_ready && out_valid)

  `SHS_ASSERT_NXT(a_index_step, out_valid && out_ready && !out_data.last_word,
                  out_valid && (out_data.word_index == $past(out_data.word_index) + 3'd1))

  `SHS_ASSERT_IMP(a_last_word, out_valid,
                  out_data.last_word == (out_data.word_index == LAST_WORD_IDX))

  `SHS_ASSERT_NXT(a_back_to_idle, out_valid && out_ready && out_data.last_word,
                  in_ready && !out_valid)

  `SHS_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb.sv =====
// testbench for sha256_stream_hasher: byte-stream hashing checked against a sha-256 digest predictor
// depends on shs_pkg for the transfer structs and on the sha256_stream_hasher rtl
`timescale 1ns / 1ps

module tb;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          LONG_HOLD    = 600;
  localparam int          DRAIN_CYCLES = 250;
  localparam int          BLOCK_BYTES  = 64;
  localparam int          LEN_OFFSET   = 56;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;
  localparam logic [2:0]  FINAL_WORD   = 3'd7;

  localparam logic [31:0] SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    shs_pkg::in_item_t item;
    logic [3:0]        gap;
    logic [3:0]        rx_max;
    logic              drain;
    logic              rx_hold;
  } stim_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  shs_pkg::in_item_t   in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  shs_pkg::out_item_t  out_data;

  stim_t               pending [$];
  shs_pkg::out_item_t  digest_q [$];
  stim_t               next_stim;
  logic                have_next = 1'b0;
  int unsigned         gap_left = 0;
  logic                in_took = 1'b0;
  logic                out_took = 1'b0;
  logic [3:0]          rx_stall_max = '0;
  int unsigned         rx_hold_reqs = 0;
  int unsigned         rx_hold_seen = 0;
  int unsigned         hold_left = 0;
  int unsigned         stall_left = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycles = 0;

  // running digest state
  logic [31:0]         run_hash [0:7];
  logic [7:0]          msg_blk [0:63];
  int unsigned         fill;
  logic [63:0]         bit_len;

  sha256_stream_hasher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_digest();
    int i;
    for (i = 0; i < 8; i++) run_hash[i] = SHA_IV[i];
    fill = 0;
    bit_len = '0;
  endtask

  task automatic sha_compress();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] t1;
    logic [31:0] t2;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {msg_blk[4*i], msg_blk[4*i+1], msg_blk[4*i+2], msg_blk[4*i+3]};
    for (i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (i = 0; i < 8; i++) v[i] = run_hash[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) run_hash[i] = run_hash[i] + v[i];
  endtask

  task automatic absorb_item(input shs_pkg::in_item_t it);
    shs_pkg::out_item_t word;
    int i;
    if (it.has_byte) begin
      msg_blk[fill] = it.data_byte;
      fill++;
      bit_len = bit_len + BITS_PER_BYTE;
      if (fill == BLOCK_BYTES) begin
        sha_compress();
        fill = 0;
      end
    end
    if (it.last) begin
      msg_blk[fill] = PAD_MARK;
      fill++;
      // no room for the length field, spill into an extra block
      if (fill > LEN_OFFSET) begin
        for (i = fill; i < BLOCK_BYTES; i++) msg_blk[i] = '0;
        sha_compress();
        fill = 0;
      end
      for (i = fill; i < LEN_OFFSET; i++) msg_blk[i] = '0;
      for (i = 0; i < 8; i++) msg_blk[BLOCK_BYTES - 1 - i] = bit_len[8*i +: 8];
      sha_compress();
      for (i = 0; i < 8; i++) begin
        word.digest_word = run_hash[i];
        word.word_index  = i[2:0];
        word.last_word   = (i[2:0] == FINAL_WORD);
        digest_q.push_back(word);
      end
      restart_digest();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_item(input logic [7:0] data, input logic has, input logic fin,
                           input int gmax, input logic drain, input logic hold);
    stim_t s;
    s.item.data_byte = data;
    s.item.has_byte  = has;
    s.item.last      = fin;
    s.gap     = 4'($urandom_range(0, gmax));
    s.rx_max  = 4'(gmax);
    s.drain   = drain;
    s.rx_hold = hold;
    pending.push_back(s);
  endtask

  task automatic push_message(input int len, input int gmax, input logic drain,
                              input logic hold);
    logic glued;
    logic pend_drain;
    logic end_here;
    int i;
    glued = (len != 0) && ($urandom_range(0, 1) == 1);
    pend_drain = drain;
    for (i = 0; i < len; i++) begin
      // idle noise between message bytes
      if ($urandom_range(0, 9) == 0) begin
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, gmax, pend_drain, 1'b0);
        pend_drain = 1'b0;
      end
      end_here = glued && (i == len - 1);
      push_item(8'($urandom_range(0, 255)), 1'b1, end_here, gmax, pend_drain,
                hold && end_here);
      pend_drain = 1'b0;
    end
    if (!glued) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, gmax, pend_drain, hold);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (!have_next && pending.size() != 0) begin
        next_stim = pending.pop_front();
        have_next = 1'b1;
        gap_left = {28'd0, next_stim.gap};
      end
      if (have_next && gap_left == 0 && !(next_stim.drain && digest_q.size() != 0)) begin
        in_valid     <= 1'b1;
        in_data      <= next_stim.item;
        rx_stall_max <= next_stim.rx_max;
        if (next_stim.rx_hold) rx_hold_reqs <= rx_hold_reqs + 1;
        have_next = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (have_next && gap_left != 0) gap_left--;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_hold_reqs != rx_hold_seen) begin
        rx_hold_seen = rx_hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (out_took) stall_left = $urandom_range(0, rx_stall_max);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (in_valid && in_ready) absorb_item(in_data);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: no digest word expected, got %h index %0d last %b", $time,
                   out_data.digest_word, out_data.word_index, out_data.last_word);
          mismatches++;
        end else begin
          check_field("digest_word", digest_q[0].digest_word, out_data.digest_word);
          check_field("word_index", 32'(digest_q[0].word_index), 32'(out_data.word_index));
          check_field("last_word", 32'(digest_q[0].last_word), 32'(out_data.last_word));
          void'(digest_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

  initial begin
    int byte_items;
    int msg;
    int len;
    int pick;
    int gmax;
    int i;
    restart_digest();
    for (i = 0; i < BLOCK_BYTES; i++) msg_blk[i] = '0;

    // empty messages, ignored bytes, idle items
    push_item(8'ha5, 1'b0, 1'b1, 9, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b0, 9, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 9, 1'b0, 1'b0);
    // byte and end in one transfer
    push_item(8'h61, 1'b1, 1'b0, 9, 1'b0, 1'b0);
    push_item(8'h62, 1'b1, 1'b0, 9, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 9, 1'b0, 1'b0);
    // extreme bytes, separate end
    push_item(8'h00, 1'b1, 1'b0, 9, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0, 9, 1'b0, 1'b0);
    push_item(8'h3c, 1'b0, 1'b0, 9, 1'b0, 1'b0);
    push_item(8'hc3, 1'b0, 1'b1, 9, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b1, 9, 1'b0, 1'b0);
    push_message(8, 9, 1'b0, 1'b0);

    byte_items = 0;
    msg = 0;
    while (byte_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 6);
      else if (pick < 9) len = 55 + $urandom_range(0, 10);
      else len = 110 + $urandom_range(0, 20);
      gmax = (msg == 4 || msg == 5 || msg % 7 == 6) ? 0 : 9;
      push_message(len, gmax, msg % 5 == 0, msg == 3);
      byte_items += len + 1;
      msg++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || have_next || in_valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/shs_pkg.sv
rtl/shs_core.sv
rtl/sha256_stream_hasher.sv
rtl/shs_checker.sv
bench/tb.sv
